>>> hdl/itrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared widths, link and control types and the digit character map for the
// integer to radix digits converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_W        = 64;
    localparam int BASE_W         = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 8;
    localparam int MAX_DIGITS_DEF = 64;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    // data handed from one cell to the next
    typedef struct packed {
        logic               carry;
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } itrd_link_t;

    // broadcast control for the whole row
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [BASE_W-1:0] base;
    } itrd_ctrl_t;

    // maps a digit value to lower-case ascii "0123456789abcdef"
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
        begin
            c = CHAR_W'(48) + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_W'(87) + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/integer_to_radix_digits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a 64-bit unsigned or signed value to base 2..16 ascii digits.
// ----------------------------------------------------------------------------
// An item passes through these steps: the block accepts it, the operand bits
// enter the cell row most significant bit first until the last carry
// wavefront reaches the top cell, then the row shifts toward the output once
// per leading zero position skipped, and after a step to leave the skip phase
// it shifts once per digit sent while the output register is free. The row
// length and the carry ripple of one cell per cycle set the conversion time.
// Digits leave most significant first, at least one digit, tlast on the final
// one; signed inputs give the digits of the magnitude with no sign. A new
// transaction is taken once the last digit sits in the output register.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // value [63:0], base [68:64], zero pad [71:69]
    input  wire logic [itrd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [0]
    input  wire logic [0:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // digit_char [6:0], zero pad [7]
    output logic [itrd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import itrd_pkg::*;

    localparam int CONV_END = VALUE_W - 1 + MAX_DIGITS;
    localparam int CNT_W    = $clog2(CONV_END + 1);
    localparam int REM_W    = $clog2(MAX_DIGITS + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_END);
    localparam logic [CNT_W-1:0] FEED_LEN = CNT_W'(VALUE_W);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [REM_W-1:0]    rem_reg,    rem_next;
    logic [VALUE_W-1:0]  val_reg,    val_next;
    logic [BASE_W-1:0]   base_reg,   base_next;
    logic                ovf_reg,    ovf_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg,  m_char_next;
    logic                m_last_reg,  m_last_next;

    logic [VALUE_W-1:0]  in_value;
    logic [BASE_W-1:0]   in_base;
    logic                in_kind;
    logic [VALUE_W-1:0]  magnitude;
    logic [BASE_W-1:0]   base_clamped;
    logic                accept;
    logic                out_free;
    logic                skip_shift;
    logic                emit_load;

    itrd_ctrl_t          row_ctrl;
    itrd_link_t          row_in;
    itrd_link_t          row_top;

    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign in_base  = s_axis_tdata[VALUE_W+BASE_W-1:VALUE_W];
    assign in_kind  = s_axis_tuser[0];

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign out_free = ~m_valid_reg | m_axis_tready;

    // the most negative value negates to itself, which reads as 2^63 unsigned
    assign magnitude = (in_kind & in_value[VALUE_W-1]) ? (~in_value + VALUE_W'(1))
                                                       : in_value;

    always_comb
    begin
        if (in_base < BASE_MIN)
        begin
            base_clamped = BASE_MIN;
        end
        else if (in_base > BASE_MAX)
        begin
            base_clamped = BASE_MAX;
        end
        else
        begin
            base_clamped = in_base;
        end
    end

    // leading zeros are dropped, keeping at least one digit, unless the value overflowed the row
    assign skip_shift = (state_reg == ST_SKIP) && (row_top.digit == '0) && !ovf_reg
                        && (rem_reg > REM_ONE);
    assign emit_load  = (state_reg == ST_EMIT) && out_free;

    assign row_ctrl.clear = accept;
    assign row_ctrl.shift = skip_shift | emit_load;
    assign row_ctrl.base  = base_reg;

    assign row_in.carry = val_reg[VALUE_W-1];
    assign row_in.valid = (state_reg == ST_CONV) && (cnt_reg < FEED_LEN);
    assign row_in.digit = '0;

    itrd_row #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_row
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (row_ctrl),
        .link_in  (row_in),
        .link_out (row_top)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        val_next     = val_reg;
        base_next    = base_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = magnitude;
                    base_next  = base_clamped;
                    cnt_next   = '0;
                    rem_next   = REM_FULL;
                    ovf_next   = 1'b0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                val_next = {val_reg[VALUE_W-2:0], 1'b0};
                ovf_next = ovf_reg | (row_top.valid & row_top.carry);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (skip_shift)
                begin
                    rem_next = rem_reg - REM_ONE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(row_top.digit);
                    m_last_next  = (rem_reg == REM_ONE);
                    rem_next     = rem_reg - REM_ONE;
                    if (rem_reg == REM_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        base_reg   <= base_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, m_char_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // the digit counter never runs dry while digits are still owed
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("digit counter empty during output");

    // every digit sent is a lower-case hex character
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[6:0] >= 7'd48 && m_axis_tdata[6:0] <= 7'd57)
                        || (m_axis_tdata[6:0] >= 7'd97 && m_axis_tdata[6:0] <= 7'd102)))
        else $error("illegal digit character");

    // loading the final digit returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && rem_reg == REM_ONE) |=> (state_reg == ST_IDLE && m_axis_tlast))
        else $error("final digit did not end the item");

    // a new transaction starts with a clean overflow mark and a full counter
    a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!ovf_reg && rem_reg == REM_FULL && state_reg == ST_CONV))
        else $error("item start not initialized");
`endif

endmodule

`default_nettype wire

>>> hdl/itrd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_cell
// One digit position of the row: doubles its digit and adds the incoming
// carry modulo the base, or shifts in its neighbor's digit during output.
// ----------------------------------------------------------------------------
module itrd_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire itrd_pkg::itrd_ctrl_t ctrl,
    input  wire itrd_pkg::itrd_link_t link_in,
    output itrd_pkg::itrd_link_t      link_out
);
    import itrd_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic               carry_reg;
    logic               valid_reg;

    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   diff;
    logic               ge;

    // 2*d + carry, compared against the base
    assign sum  = {digit_reg, link_in.carry};
    assign ge   = (sum >= ctrl.base);
    assign diff = sum - ctrl.base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            carry_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid & ~ctrl.shift;
            carry_reg <= link_in.valid & ~ctrl.shift & ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            digit_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            digit_reg <= link_in.digit;
        end
        else if (link_in.valid)
        begin
            digit_reg <= ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
        end
    end

    assign link_out.carry = carry_reg;
    assign link_out.valid = valid_reg;
    assign link_out.digit = digit_reg;

endmodule

`default_nettype wire

>>> hdl/itrd_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_row
// Chain of digit cells, least significant at the input end. Carries ripple
// one cell per cycle, so each operand bit travels up the row as a wavefront.
// ----------------------------------------------------------------------------
module itrd_row #(
    parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire itrd_pkg::itrd_ctrl_t ctrl,
    input  wire itrd_pkg::itrd_link_t link_in,
    output itrd_pkg::itrd_link_t      link_out
);
    import itrd_pkg::*;

    itrd_link_t links [MAX_DIGITS+1];

    assign links[0] = link_in;

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        itrd_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    assign link_out = links[MAX_DIGITS];

endmodule

`default_nettype wire
